>>> sv/matrix3x3_inverse_core_macros.svh
// Assertion macros for the 3x3 inverse core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MATRIX3X3_INVERSE_CORE_MACROS_SVH
`define MATRIX3X3_INVERSE_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define M3I_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3i: %s failed", "label");

// consequent must hold a fixed number of cycles after the antecedent
`define M3I_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("m3i: %s failed", "label");

`endif

>>> sv/m3i_pkg.sv
// Shared widths, types and tables for the 3x3 inverse core.
// No dependencies.
`timescale 1ns / 1ps
package m3i_pkg;

    localparam int ELEM_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int LO_W      = ELEM_W;
    localparam int HI_W      = COF_W - LO_W;
    localparam int PART_W    = ELEM_W + HI_W;
    localparam int DET_W     = ELEM_W + COF_W + 2;
    localparam int DET_MAG_W = DET_W - 1;
    localparam int DEN_W     = DET_MAG_W + 1;
    localparam int QBITS     = ELEM_W + 1;
    localparam int DIV_W     = DEN_W + QBITS;
    localparam int DRND_W    = DET_MAG_W - 2 * FRAC_W + 1;
    localparam int EPS_W     = 31;
    localparam int LANE_LAT  = QBITS + 1;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(17);

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_in_t;

    typedef struct packed {
        logic             ovf;
        logic             neg;
        logic [QBITS-1:0] quo;
    } div_out_t;

    typedef struct packed {
        logic  vld;
        logic  singular;
        elem_t det;
    } side_t;

    // adjugate entry k = m[p]*m[q] - m[r]*m[s], row-major element order
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // apply sign and saturate a magnitude to the element range
    function automatic elem_t sat_elem(input logic neg, input logic ovf,
                                       input logic [QBITS-1:0] mag);
        logic [QBITS-1:0] lim;
        elem_t            res;
        lim = QBITS'(1) << (ELEM_W - 1);
        if (neg) begin
            if (ovf || mag > lim) res = {1'b1, {(ELEM_W-1){1'b0}}};
            else                  res = elem_t'(-mag);
        end
        else begin
            if (ovf || mag >= lim) res = {1'b0, {(ELEM_W-1){1'b1}}};
            else                   res = elem_t'(mag);
        end
        return res;
    endfunction

endpackage

>>> sv/m3i_cofactor.sv
// Two-stage adjugate: products, then differences.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_cofactor
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  vld_in,
    input  elem_t m_in [9],
    output logic  vld_out,
    output cof_t  adj_out [9],
    output elem_t col_out [3]
);

    logic  vld1_reg, vld2_reg;
    prod_t pa_reg [9];
    prod_t pb_reg [9];
    elem_t col1_reg [3];
    elem_t col2_reg [3];
    cof_t  adj_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            pa_reg[k]  <= m_in[COF_IDX[k][0]] * m_in[COF_IDX[k][1]];
            pb_reg[k]  <= m_in[COF_IDX[k][2]] * m_in[COF_IDX[k][3]];
            adj_reg[k] <= $signed({pa_reg[k][PROD_W-1], pa_reg[k]})
                        - $signed({pb_reg[k][PROD_W-1], pb_reg[k]});
        end
        for (int c = 0; c < 3; c++)
        begin
            col1_reg[c] <= m_in[3 * c];
            col2_reg[c] <= col1_reg[c];
        end
    end

    assign vld_out = vld2_reg;
    assign adj_out = adj_reg;
    assign col_out = col2_reg;

endmodule

>>> sv/m3i_det.sv
// Two-stage determinant: split partial products, then the sum.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_det
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  vld_in,
    input  cof_t  adj_in [9],
    input  elem_t col_in [3],
    output logic  vld_out,
    output cof_t  adj_out [9],
    output det_t  det_out
);

    logic        vld1_reg, vld2_reg;
    logic signed [PART_W-1:0] plo_reg [3];
    logic signed [PART_W-1:0] phi_reg [3];
    cof_t        adj1_reg [9];
    cof_t        adj2_reg [9];
    det_t        det_reg;
    det_t        det_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    always_comb
    begin
        det_next = '0;
        for (int t = 0; t < 3; t++)
        begin
            det_next = det_next
                + ($signed({{(DET_W-PART_W){phi_reg[t][PART_W-1]}}, phi_reg[t]}) <<< LO_W)
                + $signed({{(DET_W-PART_W){plo_reg[t][PART_W-1]}}, plo_reg[t]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
        begin
            plo_reg[t] <= col_in[t] * $signed({1'b0, adj_in[t][LO_W-1:0]});
            phi_reg[t] <= col_in[t] * $signed(adj_in[t][COF_W-1:LO_W]);
        end
        adj1_reg <= adj_in;
        adj2_reg <= adj1_reg;
        det_reg  <= det_next;
    end

    assign vld_out = vld2_reg;
    assign adj_out = adj2_reg;
    assign det_out = det_reg;

endmodule

>>> sv/m3i_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage, plus overflow check.
// Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_div_lane
    import m3i_pkg::*;
(
    input  logic     clk,
    input  div_in_t  din,
    output div_out_t dout
);

    logic [DIV_W-1:0] rem_reg [QBITS+1];
    logic [DEN_W-1:0] den_reg [QBITS+1];
    logic [QBITS-1:0] quo_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];

    // overflow when the quotient would need more than QBITS bits
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= din.num;
        den_reg[0] <= din.den;
        quo_reg[0] <= '0;
        neg_reg[0] <= din.neg;
        ovf_reg[0] <= din.num >= (DIV_W'(din.den) << QBITS);
    end

    for (genvar s = 0; s < QBITS; s++)
    begin : g_step
        localparam int K = QBITS - 1 - s;
        logic [DIV_W-1:0] trial;
        assign trial = DIV_W'(den_reg[s]) << K;

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
            if (rem_reg[s] >= trial)
            begin
                rem_reg[s+1] <= rem_reg[s] - trial;
                quo_reg[s+1] <= quo_reg[s] | (QBITS'(1) << K);
            end
            else
            begin
                rem_reg[s+1] <= rem_reg[s];
                quo_reg[s+1] <= quo_reg[s];
            end
        end
    end

    assign dout.ovf = ovf_reg[QBITS];
    assign dout.neg = neg_reg[QBITS];
    assign dout.quo = quo_reg[QBITS];

endmodule

>>> sv/matrix3x3_inverse_core.sv
// 3x3 fixed-point inverse by adjugate; done marks each result.
// Throughput one matrix per cycle: busy is always low, every stage advances each clock.
// The divider lanes' 33 quotient stages (one quotient bit per stage) set most of the latency.
// Reset clears all valid bits and loads det_epsilon with 17; results cannot be stalled.
// Depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_div_lane and the macros header.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_core_macros.svh"
module matrix3x3_inverse_core
    import m3i_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              det_epsilon_we,
    input  logic [EPS_W-1:0]  det_epsilon_wdata,
    input  elem_t             in_r0c0,
    input  elem_t             in_r0c1,
    input  elem_t             in_r0c2,
    input  elem_t             in_r1c0,
    input  elem_t             in_r1c1,
    input  elem_t             in_r1c2,
    input  elem_t             in_r2c0,
    input  elem_t             in_r2c1,
    input  elem_t             in_r2c2,
    output logic              done,
    output elem_t             out_r0c0,
    output elem_t             out_r0c1,
    output elem_t             out_r0c2,
    output elem_t             out_r1c0,
    output elem_t             out_r1c1,
    output elem_t             out_r1c2,
    output elem_t             out_r2c0,
    output elem_t             out_r2c1,
    output elem_t             out_r2c2,
    output elem_t             determinant,
    output logic              singular
);

    localparam int LATENCY = 40;

    // The pipeline never stalls, so a new transfer is taken every cycle.
    assign busy = 1'b0;

    logic [EPS_W-1:0] det_epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) det_epsilon_reg <= EPS_RESET;
        else if (det_epsilon_we) det_epsilon_reg <= det_epsilon_wdata;
    end

    // Stages 1-2: adjugate.
    elem_t m_in [9];
    assign m_in = '{in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                    in_r2c0, in_r2c1, in_r2c2};

    logic  cof_vld;
    cof_t  cof_adj [9];
    elem_t cof_col [3];

    m3i_cofactor u_cofactor (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (start && !busy),
        .m_in    (m_in),
        .vld_out (cof_vld),
        .adj_out (cof_adj),
        .col_out (cof_col)
    );

    // Stages 3-4: determinant along the first column.
    logic det_vld;
    cof_t det_adj [9];
    det_t det_val;

    m3i_det u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (cof_vld),
        .adj_in  (cof_adj),
        .col_in  (cof_col),
        .vld_out (det_vld),
        .adj_out (det_adj),
        .det_out (det_val)
    );

    // Stage 5: magnitudes, rounding offsets, singular test, determinant output.
    logic [DET_MAG_W-1:0] det_mag;
    logic                 det_neg;
    logic [DRND_W-1:0]    det_rnd;
    logic                 sing_next;
    div_in_t              div_in_next [9];
    side_t                side_next;
    div_in_t              div_in_reg [9];
    side_t                side_reg;

    always_comb
    begin
        logic [COF_W-1:0]  adj_abs;
        logic [DIV_W-1:0]  num;
        det_neg   = det_val[DET_W-1];
        det_mag   = det_neg ? DET_MAG_W'(-det_val) : DET_MAG_W'(det_val);
        // round half away from zero on the magnitude, drop 2*FRAC_W fraction bits
        det_rnd   = DRND_W'((DET_MAG_W'(det_mag) + (DET_MAG_W'(1) << (2 * FRAC_W - 1)))
                    >> (2 * FRAC_W));
        sing_next = (det_mag < (DET_MAG_W'(det_epsilon_reg) << (2 * FRAC_W)))
                    || (det_val == '0);
        for (int k = 0; k < 9; k++)
        begin
            adj_abs = det_adj[k][COF_W-1] ? COF_W'(-det_adj[k]) : COF_W'(det_adj[k]);
            // numerator 2|adj|*2^(2F) + |det|, denominator 2|det|: rounds to nearest
            num = (DIV_W'(adj_abs[PROD_W-1:0]) << (2 * FRAC_W + 1)) + DIV_W'(det_mag);
            div_in_next[k].num = num;
            div_in_next[k].den = {det_mag, 1'b0};
            div_in_next[k].neg = det_adj[k][COF_W-1] ^ det_neg;
        end
        side_next.vld      = det_vld;
        side_next.singular = sing_next;
        side_next.det      = sat_elem(det_neg, |det_rnd[DRND_W-1:QBITS],
                                      det_rnd[QBITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        div_in_reg <= div_in_next;
    end

    // Hold the determinant and flag alongside the divider lanes.
    side_t side_pipe_reg [LANE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
            for (int s = 0; s < LANE_LAT; s++) side_pipe_reg[s] <= '0;
        end
        else
        begin
            side_reg         <= side_next;
            side_pipe_reg[0] <= side_reg;
            for (int s = 1; s < LANE_LAT; s++) side_pipe_reg[s] <= side_pipe_reg[s-1];
        end
    end

    // Stages 6-39: nine divider lanes.
    div_out_t div_out [9];

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk  (clk),
            .din  (div_in_reg[k]),
            .dout (div_out[k])
        );
    end

    // Stage 40: saturate, zero on singular, drive the result registers.
    side_t last_side;
    assign last_side = side_pipe_reg[LANE_LAT-1];

    elem_t res_next [9];
    elem_t res_reg [9];
    elem_t det_reg;
    logic  sing_reg;
    logic  done_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            if (last_side.singular) res_next[k] = '0;
            else res_next[k] = sat_elem(div_out[k].neg, div_out[k].ovf, div_out[k].quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= last_side.vld;
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        det_reg  <= last_side.det;
        sing_reg <= last_side.singular;
    end

    assign done        = done_reg;
    assign out_r0c0    = res_reg[0];
    assign out_r0c1    = res_reg[1];
    assign out_r0c2    = res_reg[2];
    assign out_r1c0    = res_reg[3];
    assign out_r1c1    = res_reg[4];
    assign out_r1c2    = res_reg[5];
    assign out_r2c0    = res_reg[6];
    assign out_r2c1    = res_reg[7];
    assign out_r2c2    = res_reg[8];
    assign determinant = det_reg;
    assign singular    = sing_reg;

    // every transfer yields a done strobe after the fixed latency
    `M3I_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
    // a strobe without a transfer that far back would be an invented result
    `M3I_ASSERT_IMPL(a_no_invent, done, $past(start && !busy, LATENCY))
    // singular results carry zero elements
    `M3I_ASSERT_IMPL(a_sing_zero, done && singular,
        out_r0c0 == '0 && out_r1c1 == '0 && out_r2c2 == '0 && out_r0c2 == '0)

endmodule
